// ===== hdl/highpass_leaky_nlms_canceller_assert.svh =====
// Assertion macros used by the checker file.
`ifndef HIGHPASS_LEAKY_NLMS_CANCELLER_ASSERT_SVH
`define HIGHPASS_LEAKY_NLMS_CANCELLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HLNC_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HLNC_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hlnc_pkg.sv =====
`default_nettype none

package hlnc_pkg;

  localparam int TAPS     = 16;
  localparam int LAG      = 10;
  localparam int LINE_LEN = TAPS + LAG;
  localparam int TAP_W    = $clog2(TAPS);
  localparam int LINE_W   = $clog2(LINE_LEN);

  localparam int SMP_W  = 16;
  localparam int WGT_W  = 24;
  localparam int STEP_W = 16;
  localparam int MU_W   = 24;
  localparam int ACC_W  = WGT_W + SMP_W + TAP_W;
  localparam int EST_W  = ACC_W - 21;
  localparam int ENG_W  = 2 * SMP_W + TAP_W + 1;
  localparam int NUM_W  = MU_W + STEP_W;
  localparam int DSH_W  = ENG_W + STEP_W - 1;
  localparam int CNT_W  = (TAP_W > $clog2(STEP_W)) ? TAP_W : $clog2(STEP_W);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [15:0] ALPHA_RST = 16'd64520;
  localparam logic [23:0] MU_RST    = 24'd33554;
  localparam logic [15:0] LEAK_RST  = 16'd65470;
  localparam logic [15:0] LIMIT_RST = 16'd3277;
  localparam logic [23:0] FLOOR_RST = 24'd16777;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HP_ALPHA     = 3'd0,
    REG_STEP_SIZE    = 3'd1,
    REG_LEAK_FACTOR  = 3'd2,
    REG_STEP_LIMIT   = 3'd3,
    REG_ENERGY_FLOOR = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [23:0] mu;
    logic [15:0] leak;
    logic [15:0] limit;
    logic [23:0] floor_e;
  } cfg_t;

  typedef struct packed {
    logic             take;
    logic             hp_mul;
    logic             hp_fin;
    logic             sum_rd;
    logic             est;
    logic             div_step;
    logic             step;
    logic             se;
    logic             upd_rd;
    logic             out_load;
    logic [TAP_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hlnc_cfg.sv =====
`default_nettype none

module hlnc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hlnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hlnc_pkg::CFG_DAT_W-1:0] cfg_data,
  output hlnc_pkg::cfg_t                      cfg
);

  hlnc_pkg::cfg_t cfg_r;
  hlnc_pkg::cfg_t cfg_nxt;

  assign cfg_ready = rst_n;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        hlnc_pkg::REG_HP_ALPHA:     cfg_nxt.alpha   = cfg_data[15:0];
        hlnc_pkg::REG_STEP_SIZE:    cfg_nxt.mu      = cfg_data[23:0];
        hlnc_pkg::REG_LEAK_FACTOR:  cfg_nxt.leak    = cfg_data[15:0];
        hlnc_pkg::REG_STEP_LIMIT:   cfg_nxt.limit   = cfg_data[15:0];
        hlnc_pkg::REG_ENERGY_FLOOR: cfg_nxt.floor_e = cfg_data[23:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha   <= hlnc_pkg::ALPHA_RST;
      cfg_r.mu      <= hlnc_pkg::MU_RST;
      cfg_r.leak    <= hlnc_pkg::LEAK_RST;
      cfg_r.limit   <= hlnc_pkg::LIMIT_RST;
      cfg_r.floor_e <= hlnc_pkg::FLOOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hlnc_ctrl.sv =====
`default_nettype none

module hlnc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire hlnc_pkg::sts_t sts,
  output hlnc_pkg::cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_HPMUL = 12'b0000_0000_0010,
    S_HPFIN = 12'b0000_0000_0100,
    S_SUM   = 12'b0000_0000_1000,
    S_SUMW  = 12'b0000_0001_0000,
    S_EST   = 12'b0000_0010_0000,
    S_DIV   = 12'b0000_0100_0000,
    S_STEP  = 12'b0000_1000_0000,
    S_SE    = 12'b0001_0000_0000,
    S_UPD   = 12'b0010_0000_0000,
    S_UPDW  = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  localparam logic [hlnc_pkg::CNT_W-1:0] TAP_LAST = hlnc_pkg::CNT_W'(hlnc_pkg::TAPS - 1);
  localparam logic [hlnc_pkg::CNT_W-1:0] DIV_LAST = hlnc_pkg::CNT_W'(hlnc_pkg::STEP_W - 1);

  state_t                      state_r, state_nxt;
  logic [hlnc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE) && rst_n;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r[hlnc_pkg::TAP_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_HPMUL;
        end
      end
      S_HPMUL: begin
        cmd.hp_mul = 1'b1;
        state_nxt  = S_HPFIN;
      end
      S_HPFIN: begin
        cmd.hp_fin = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_rd = 1'b1;
        if (cnt_r == TAP_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_SUMW;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SUMW: begin
        state_nxt = S_EST;
      end
      S_EST: begin
        cmd.est   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_STEP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_SE;
      end
      S_SE: begin
        cmd.se    = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd_rd = 1'b1;
        if (cnt_r == TAP_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_UPDW;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_UPDW: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hlnc_dp.sv =====
`default_nettype none

module hlnc_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hlnc_pkg::cfg_t     cfg,
  input  wire hlnc_pkg::cmd_t     cmd,
  output hlnc_pkg::sts_t          sts,
  input  wire logic signed [15:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_highpassed,
  output logic signed [15:0]      out_cleaned
);

  localparam int ACC_W = hlnc_pkg::ACC_W;
  localparam int EST_W = hlnc_pkg::EST_W;
  localparam int ENG_W = hlnc_pkg::ENG_W;
  localparam int NUM_W = hlnc_pkg::NUM_W;
  localparam int DSH_W = hlnc_pkg::DSH_W;
  localparam int STP_W = hlnc_pkg::STEP_W;

  // high-pass state
  logic signed [15:0] x_r;
  logic signed [15:0] hp_in_r;
  logic signed [15:0] hp_out_r;
  logic               primed_r;
  logic signed [34:0] hpp_r;
  logic signed [15:0] hp_r;

  logic signed [15:0] line_r [hlnc_pkg::LINE_LEN];
  logic signed [23:0] w_r    [hlnc_pkg::TAPS];

  // estimate / energy pass
  logic signed [39:0]      pw_r;
  logic [31:0]             pe_r;
  logic                    pv_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [ENG_W-1:0]        eng_r;
  logic signed [15:0]      err_r;

  // step divider
  logic [NUM_W-1:0] rem_r;
  logic [DSH_W-1:0] dsh_r;
  logic [STP_W-1:0] q_r;
  logic             clamp_r;
  logic [STP_W-1:0] step_r;
  logic signed [32:0] se_r;

  // weight update pass
  logic signed [40:0]                 pl_r;
  logic signed [48:0]                 pu_r;
  logic                               uv_r;
  logic [hlnc_pkg::TAP_W-1:0]         ui_r;

  logic signed [15:0] out_hp_r;
  logic signed [15:0] out_cl_r;
  logic               out_valid_r;

  logic signed [17:0]       hp_d;
  logic signed [34:0]       hp_rnd;
  logic signed [15:0]       hp_val;
  logic signed [15:0]       rd_line;
  logic signed [23:0]       rd_w;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [EST_W-1:0]  est_v;
  logic signed [EST_W:0]    diff_v;
  logic                     clamp_v;
  logic                     div_ge;
  logic signed [50:0]       upd_sum;
  logic signed [23:0]       w_new;

  always_comb begin
    hp_d    = $signed({{2{hp_out_r[15]}}, hp_out_r}) + $signed({{2{x_r[15]}}, x_r})
              - $signed({{2{hp_in_r[15]}}, hp_in_r});
    hp_rnd  = hpp_r + 35'sd32768;
    hp_val  = primed_r ? hlnc_pkg::sat16($signed({{5{hp_rnd[34]}}, hp_rnd[34:16]}))
                       : 16'sd0;
    rd_line = line_r[hlnc_pkg::LINE_W'(cmd.idx) + hlnc_pkg::LINE_W'(hlnc_pkg::LAG)];
    rd_w    = w_r[cmd.idx];
    acc_rnd = acc_r + $signed({{(ACC_W-21){1'b0}}, 1'b1, 20'b0});
    est_v   = acc_rnd[ACC_W-1:21];
    diff_v  = $signed({hp_r[15], {(EST_W-16){hp_r[15]}}, hp_r})
              - $signed({est_v[EST_W-1], est_v});
    clamp_v = {{(ENG_W+STP_W-NUM_W){1'b0}}, cfg.mu, {STP_W{1'b0}}}
              >= {eng_r, {STP_W{1'b0}}};
    div_ge  = {{(DSH_W-NUM_W){1'b0}}, rem_r} >= dsh_r;
    upd_sum = ($signed({{10{pl_r[40]}}, pl_r}) <<< 3)
              + ($signed({{2{pu_r[48]}}, pu_r}) <<< 1) + 51'sd262144;
    w_new   = hlnc_pkg::sat24(upd_sum[50:19]);
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_r <= in_sample;
    end
    if (cmd.hp_mul) begin
      hpp_r <= $signed({1'b0, cfg.alpha}) * hp_d;
    end
    if (cmd.sum_rd) begin
      pw_r <= rd_w * rd_line;
      pe_r <= 32'(rd_line * rd_line);
    end
    if (cmd.est) begin
      err_r   <= hlnc_pkg::sat16(diff_v);
      rem_r   <= {cfg.mu, {STP_W{1'b0}}};
      dsh_r   <= {eng_r, {(STP_W-1){1'b0}}};
      clamp_r <= clamp_v;
      q_r     <= '0;
    end
    if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - dsh_r[NUM_W-1:0];
      end
      q_r   <= {q_r[STP_W-2:0], div_ge};
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.step) begin
      step_r <= (clamp_r || (q_r > cfg.limit)) ? cfg.limit : q_r;
    end
    if (cmd.se) begin
      se_r <= $signed({1'b0, step_r}) * err_r;
    end
    if (cmd.upd_rd) begin
      pl_r <= $signed({1'b0, cfg.leak}) * rd_w;
      pu_r <= se_r * rd_line;
      ui_r <= cmd.idx;
    end
    if (cmd.out_load) begin
      out_hp_r <= hp_r;
      out_cl_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_in_r     <= '0;
      hp_out_r    <= '0;
      hp_r        <= '0;
      primed_r    <= 1'b0;
      pv_r        <= 1'b0;
      uv_r        <= 1'b0;
      acc_r       <= '0;
      eng_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < hlnc_pkg::LINE_LEN; i++) begin
        line_r[i] <= '0;
      end
      for (int i = 0; i < hlnc_pkg::TAPS; i++) begin
        w_r[i] <= '0;
      end
    end else begin
      pv_r <= cmd.sum_rd;
      uv_r <= cmd.upd_rd;
      if (cmd.hp_fin) begin
        hp_r      <= hp_val;
        hp_in_r   <= x_r;
        hp_out_r  <= hp_val;
        primed_r  <= 1'b1;
        line_r[0] <= hp_val;
        for (int i = 1; i < hlnc_pkg::LINE_LEN; i++) begin
          line_r[i] <= line_r[i-1];
        end
        acc_r <= '0;
        eng_r <= ENG_W'(cfg.floor_e);
      end else if (pv_r) begin
        acc_r <= acc_r + $signed({{(ACC_W-40){pw_r[39]}}, pw_r});
        eng_r <= eng_r + ENG_W'(pe_r);
      end
      if (uv_r) begin
        w_r[ui_r] <= w_new;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_highpassed = out_hp_r;
  assign out_cleaned    = out_cl_r;

endmodule

`default_nettype wire

// ===== hdl/highpass_leaky_nlms_canceller.sv =====
// DC-blocking high-pass filter followed by a 16-tap leaky NLMS canceller that reads the
// filtered history 10 samples back and removes the predicted periodic part. Each sample
// returns the high-passed value and the cleaned value (both Q3.12, saturated); the first
// sample after reset only primes the filter and reports 0. The block handles one
// transaction at a time: a new sample is taken only once the previous result has been
// loaded into the output register. The work runs as two walks over the taps through
// one multiplier pair and a radix-2 divider for the normalised step. A finished
// result waits in the output register without blocking the next input. Configuration
// writes are taken in any cycle and should only be issued while the block is idle;
// writes to unknown indexes are dropped.
`default_nettype none

module highpass_leaky_nlms_canceller (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [15:0]             in_sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [15:0]                  out_highpassed,
  output logic signed [15:0]                  out_cleaned,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hlnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hlnc_pkg::CFG_DAT_W-1:0] cfg_data
);

  hlnc_pkg::cfg_t cfg;
  hlnc_pkg::cmd_t cmd;
  hlnc_pkg::sts_t sts;

  hlnc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hlnc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlnc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_highpassed (out_highpassed),
    .out_cleaned    (out_cleaned)
  );

endmodule

`default_nettype wire

// ===== hdl/hlnc_checker.sv =====
`default_nettype none

`include "highpass_leaky_nlms_canceller_assert.svh"

module hlnc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_highpassed,
  input wire logic signed [15:0] out_cleaned
);

  // stalled result holds
  `HLNC_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_highpassed) && $stable(out_cleaned), "stalled result changed")

  // one transaction at a time: input closes for the work that follows
  `HLNC_AST_NXT(a_in_busy, in_valid && in_ready, !in_ready ##1 !in_ready, "input reopened too early")

  // a fresh result only comes from work in progress
  `HLNC_AST_IMP(a_out_src, $rose(out_valid), $past(!in_ready), "result without pending transaction")

endmodule

bind highpass_leaky_nlms_canceller hlnc_checker u_hlnc_checker (.*);

`default_nettype wire
